// ===== rtl/i2cram_pkg.sv =====
// Package: shared types and constants for the I2C register access master.
`timescale 1ns / 1ps
package i2cram_pkg;
	localparam int MaxTransferLength = 4096;
	localparam logic [15:0] HalfPeriodReset = 16'd250;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;
	localparam logic [1:0] CMD_DATA  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NOACK   = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [6:0]  device_address;
		logic [15:0] register_address;
		logic [1:0]  address_bytes;
		logic [12:0] transfer_length;
		logic [7:0]  write_data;
		logic        sda_in;
	} in_item_t;

	typedef struct packed {
		logic        scl_out;
		logic        sda_out;
		logic        sda_released;
		logic        busy_res;
		logic        want_data;
		logic [7:0]  read_data;
		logic        read_valid;
		logic        read_last;
		logic        done_res;
		logic [1:0]  status;
	} out_item_t;

	// classified tick handed from front to back
	typedef struct packed {
		logic        start_ok;
		logic        reject;
		logic        is_read;
		logic        wide;
		logic        data_cmd;
		logic [6:0]  dev;
		logic [15:0] reg_addr;
		logic [12:0] len;
		logic [7:0]  wdata;
		logic        sda;
	} tick_t;
endpackage

// ===== rtl/i2cram_front.sv =====
// Front end: accepts ticks, validates start requests, feeds the queue.
`timescale 1ns / 1ps
module i2cram_front import i2cram_pkg::*; #(
	parameter int MAX_LEN = MaxTransferLength
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_item_t in_data,
	output logic     q_valid,
	input  logic     q_stall,
	output tick_t    q_data
);
	logic  start_cmd, bad;
	tick_t t;
	logic  s1_valid_q;
	tick_t s1_data_q;

	always_comb begin
		start_cmd = (in_data.command == CMD_WRITE) || (in_data.command == CMD_READ);
		bad = ((in_data.address_bytes != 2'd1) && (in_data.address_bytes != 2'd2)) ||
			(in_data.transfer_length == 13'd0) ||
			(32'(in_data.transfer_length) > 32'(MAX_LEN));
		t.start_ok = start_cmd && !bad;
		t.reject   = start_cmd && bad;
		t.is_read  = in_data.command == CMD_READ;
		t.wide     = in_data.address_bytes == 2'd2;
		t.data_cmd = in_data.command == CMD_DATA;
		t.dev      = in_data.device_address;
		t.reg_addr = in_data.register_address;
		t.len      = in_data.transfer_length;
		t.wdata    = in_data.write_data;
		t.sda      = in_data.sda_in;
	end

	assign in_stall = s1_valid_q && q_stall;
	assign q_valid  = s1_valid_q;
	assign q_data   = s1_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			s1_data_q <= t;
		end
	end
endmodule

// ===== rtl/i2cram_queue.sv =====
// Two-entry queue between front and back ends.
`timescale 1ns / 1ps
module i2cram_queue import i2cram_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_stall,
	input  tick_t wr_data,
	output logic  rd_valid,
	input  logic  rd_stall,
	output tick_t rd_data
);
	tick_t      mem_q [2];
	logic       wptr_q, rptr_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_stall = cnt_q == 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rptr_q];
	assign push = wr_valid && !wr_stall;
	assign pop  = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wr_data;
	end
endmodule

// ===== rtl/i2cram_back.sv =====
// Back end: bus sequencer, one tick per item, registered result output.
`timescale 1ns / 1ps
module i2cram_back import i2cram_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] half_period,
	input  logic        q_valid,
	output logic        q_stall,
	input  tick_t       q_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);
	typedef enum logic [3:0] {
		PH_IDLE, PH_S1, PH_S2, PH_WLO, PH_WHI, PH_ALO, PH_AHI, PH_ATAIL,
		PH_WAIT, PH_RLO, PH_RHI, PH_KLO, PH_KHI, PH_P1, PH_P2, PH_P3
	} phase_t;
	typedef enum logic [2:0] {
		STG_DEVW, STG_REGHI, STG_REGLO, STG_DATA, STG_DEVR, STG_READ
	} stage_t;

	phase_t      phase_q, ph;
	stage_t      stage_q, stg;
	logic [15:0] tick_q, tk, h;
	logic [3:0]  bit_q, bc;
	logic [12:0] rem_q, rem;
	logic [7:0]  shift_q, sh;
	logic [6:0]  tgt_q, tgt;
	logic [15:0] ptr_q, ptr;
	logic        wide_q, wide, rd_q, rdm, fail_q, fl;
	out_item_t   o;
	logic        go;

	assign q_stall = out_valid && out_stall;
	assign go = q_valid && !q_stall;

	always_comb begin
		ph = phase_q; stg = stage_q; tk = tick_q; bc = bit_q; rem = rem_q;
		sh = shift_q; tgt = tgt_q; ptr = ptr_q; wide = wide_q; rdm = rd_q;
		fl = fail_q;
		o = '0;
		o.scl_out = 1'b1;
		o.sda_out = 1'b1;
		h = (half_period == 16'd0) ? 16'd1 : half_period;

		if (phase_q == PH_IDLE && (q_data.start_ok || q_data.reject)) begin
			if (q_data.reject) begin
				o.done_res = 1'b1;
				o.status = ST_INVALID;
			end else begin
				tgt = q_data.dev; ptr = q_data.reg_addr; wide = q_data.wide;
				rem = q_data.len; rdm = q_data.is_read; fl = 1'b0;
				stg = STG_DEVW; tk = '0; ph = PH_S1;
			end
		end else if (phase_q == PH_WAIT && q_data.data_cmd) begin
			rem = rem - 13'd1; tk = '0;
			sh = q_data.wdata; bc = 4'd8; stg = STG_DATA; ph = PH_WLO;
		end

		unique case (ph)
			PH_S2: o.sda_out = 1'b0;
			PH_WLO: begin o.scl_out = 1'b0; o.sda_out = sh[7]; end
			PH_WHI: o.sda_out = sh[7];
			PH_ALO, PH_RLO: begin o.scl_out = 1'b0; o.sda_released = 1'b1; end
			PH_AHI, PH_RHI: o.sda_released = 1'b1;
			PH_ATAIL, PH_WAIT: o.scl_out = 1'b0;
			PH_KLO: begin o.scl_out = 1'b0; o.sda_out = rem == '0; end
			PH_KHI: o.sda_out = rem == '0;
			PH_P1: begin o.scl_out = 1'b0; o.sda_out = 1'b0; end
			PH_P2: o.sda_out = 1'b0;
			default: ;
		endcase
		o.busy_res = ph != PH_IDLE;
		o.want_data = ph == PH_WAIT;

		if (ph != PH_IDLE && ph != PH_WAIT) begin
			tk = tk + 16'd1;
			if (tk >= h) begin
				tk = '0;
				unique case (ph)
					PH_S1: ph = PH_S2;
					PH_S2: begin
						sh = (stg == STG_DEVR) ? {tgt, 1'b1} : {tgt, 1'b0};
						if (stg != STG_DEVR) stg = STG_DEVW;
						bc = 4'd8; ph = PH_WLO;
					end
					PH_WLO: ph = PH_WHI;
					PH_WHI: begin
						sh = {sh[6:0], 1'b0}; bc = bc - 4'd1;
						ph = (bc != '0) ? PH_WLO : PH_ALO;
					end
					PH_ALO: ph = PH_AHI;
					PH_AHI: begin
						if (q_data.sda) fl = 1'b1;
						ph = PH_ATAIL;
					end
					PH_ATAIL: begin
						priority if (fl) ph = PH_P1;
						else if (stg == STG_DEVW) begin
							sh = wide ? ptr[15:8] : ptr[7:0];
							stg = wide ? STG_REGHI : STG_REGLO;
							bc = 4'd8; ph = PH_WLO;
						end else if (stg == STG_REGHI) begin
							sh = ptr[7:0]; stg = STG_REGLO; bc = 4'd8; ph = PH_WLO;
						end else if (stg == STG_REGLO) begin
							if (rdm) begin stg = STG_DEVR; ph = PH_S1; end
							else begin stg = STG_DATA; ph = PH_WAIT; end
						end else if (stg == STG_DATA) begin
							ph = (rem == '0) ? PH_P1 : PH_WAIT;
						end else begin
							stg = STG_READ; sh = '0; bc = 4'd8; ph = PH_RLO;
						end
					end
					PH_RLO: ph = PH_RHI;
					PH_RHI: begin
						sh = {sh[6:0], q_data.sda}; bc = bc - 4'd1;
						if (bc != '0) ph = PH_RLO;
						else begin
							o.read_data = sh; o.read_valid = 1'b1;
							o.read_last = rem <= 13'd1;
							rem = o.read_last ? 13'd0 : rem - 13'd1;
							ph = PH_KLO;
						end
					end
					PH_KLO: ph = PH_KHI;
					PH_KHI: begin
						if (rem == '0) ph = PH_P1;
						else begin sh = '0; bc = 4'd8; ph = PH_RLO; end
					end
					PH_P1: ph = PH_P2;
					PH_P2: ph = PH_P3;
					PH_P3: begin
						o.done_res = 1'b1;
						o.status = fl ? ST_NOACK : ST_OK;
						ph = PH_IDLE;
					end
					default: ph = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; stage_q <= STG_DEVW; tick_q <= '0; bit_q <= '0;
			rem_q <= '0; shift_q <= '0; tgt_q <= '0; ptr_q <= '0;
			wide_q <= 1'b0; rd_q <= 1'b0; fail_q <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (go) begin
				phase_q <= ph; stage_q <= stg; tick_q <= tk; bit_q <= bc;
				rem_q <= rem; shift_q <= sh; tgt_q <= tgt; ptr_q <= ptr;
				wide_q <= wide; rd_q <= rdm; fail_q <= fl;
			end
			if (!q_stall) out_valid <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) out_data <= o;
	end
endmodule

// ===== rtl/i2c_register_access_master.sv =====
// Top level: I2C register access master, front end, queue, bus sequencer.
//  channel | direction | handshake        | payload
//  in      | input     | in_valid/in_stall   | in_item_t
//  out     | output    | out_valid/out_stall | out_item_t
//  cfg     | input     | cfg_we              | half_period_cycles
// One item per cycle unless stalled; items pass front register, queue, result register.
// The bus sequencer advances one tick per item; its state update is computed combinationally and registered.
// Reset clears all control state and sets the half period to 250.
// Output stall backs up through the two-entry queue to the input.
`timescale 1ns / 1ps
module i2c_register_access_master import i2cram_pkg::*; #(
	parameter int MAX_LEN = MaxTransferLength
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);
	logic [15:0] half_q;
	logic  f_valid, f_stall, b_valid, b_stall;
	tick_t f_data, b_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) half_q <= HalfPeriodReset;
		else if (cfg_we) half_q <= cfg_wdata;
	end

	i2cram_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_data,
		.q_valid(f_valid), .q_stall(f_stall), .q_data(f_data)
	);
	i2cram_queue u_queue (
		.clk, .arst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
		.rd_valid(b_valid), .rd_stall(b_stall), .rd_data(b_data)
	);
	i2cram_back u_back (
		.clk, .arst_n, .half_period(half_q), .q_valid(b_valid), .q_stall(b_stall),
		.q_data(b_data), .out_valid, .out_stall, .out_data
	);
endmodule

// ===== rtl/i2cram_checker.sv =====
// Port-level checker for the I2C register access master, with bind.
`timescale 1ns / 1ps
module i2cram_checker import i2cram_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled transfer changed");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.done_res |-> out_data.status == ST_OK)
		else $error("status without done");
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.read_last |-> out_data.read_valid)
		else $error("read_last without read_valid");
	a_want: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.want_data |-> out_data.busy_res && !out_data.scl_out)
		else $error("want_data outside busy low clock");
endmodule

bind i2c_register_access_master i2cram_checker u_checker (
	.clk, .arst_n, .out_valid, .out_stall, .out_data
);

// ===== bench/i2c_register_access_master_tb.sv =====
// Testbench: I2C register access master, tick-level prediction with random idling and stalls.
`timescale 1ns / 1ps
module i2c_register_access_master_tb;
	import i2cram_pkg::*;

	typedef enum logic [3:0] {
		P_IDLE, P_S1, P_S2, P_WLO, P_WHI, P_ALO, P_AHI, P_ATAIL, P_WAIT,
		P_RLO, P_RHI, P_KLO, P_KHI, P_P1, P_P2, P_P3
	} bus_phase_t;
	typedef enum logic [2:0] {G_DEVW, G_REGHI, G_REGLO, G_DATA, G_DEVR, G_READ} byte_stage_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;
	logic in_valid, in_stall, out_valid, out_stall;
	in_item_t in_data;
	out_item_t out_data;

	i2c_register_access_master uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// bus sequencer shadow
	logic [15:0] half_ticks;
	bus_phase_t ph;
	byte_stage_t stg;
	logic [15:0] tcnt, raddr;
	logic [3:0] bcnt;
	logic [12:0] remaining;
	logic [7:0] sbyte;
	logic [6:0] taddr;
	logic wide, rd, nack;

	in_item_t tick_queue[$];
	out_item_t bus_expected[$];
	int errors, checked, sent, in_gap, out_gap, ndone, nread, nnack;
	bit feeding;
	bit in_took, out_took;

	task automatic reset_model();
		ph = P_IDLE; stg = G_DEVW; tcnt = 0; raddr = 0; bcnt = 0; remaining = 0;
		sbyte = 0; taddr = 0; wide = 0; rd = 0; nack = 0;
	endtask

	function automatic void load_byte(input logic [7:0] v, input byte_stage_t s);
		sbyte = v; bcnt = 4'd8; stg = s; ph = P_WLO;
	endfunction

	function automatic out_item_t bus_tick(input in_item_t it);
		out_item_t o;
		logic [15:0] h;
		o = '0;
		o.scl_out = 1; o.sda_out = 1;
		h = (half_ticks == 0) ? 16'd1 : half_ticks;
		if (ph == P_IDLE && (it.command == CMD_WRITE || it.command == CMD_READ)) begin
			if ((it.address_bytes != 1 && it.address_bytes != 2) || it.transfer_length == 0
					|| it.transfer_length > MaxTransferLength) begin
				o.done_res = 1; o.status = ST_INVALID;
			end else begin
				taddr = it.device_address; raddr = it.register_address;
				wide = it.address_bytes == 2; remaining = it.transfer_length;
				rd = it.command == CMD_READ; nack = 0; stg = G_DEVW; tcnt = 0; ph = P_S1;
			end
		end else if (ph == P_WAIT && it.command == CMD_DATA) begin
			remaining = remaining - 13'd1; tcnt = 0;
			load_byte(it.write_data, G_DATA);
		end
		case (ph)
			P_S2: o.sda_out = 0;
			P_WLO: begin o.scl_out = 0; o.sda_out = sbyte[7]; end
			P_WHI: o.sda_out = sbyte[7];
			P_ALO, P_RLO: begin o.scl_out = 0; o.sda_released = 1; end
			P_AHI, P_RHI: o.sda_released = 1;
			P_ATAIL, P_WAIT: o.scl_out = 0;
			P_KLO: begin o.scl_out = 0; o.sda_out = remaining == 0; end
			P_KHI: o.sda_out = remaining == 0;
			P_P1: begin o.scl_out = 0; o.sda_out = 0; end
			P_P2: o.sda_out = 0;
			default: ;
		endcase
		o.busy_res = ph != P_IDLE;
		o.want_data = ph == P_WAIT;
		if (ph != P_IDLE && ph != P_WAIT) begin
			tcnt = tcnt + 16'd1;
			if (tcnt >= h) begin
				tcnt = 0;
				case (ph)
					P_S1: ph = P_S2;
					P_S2: if (stg == G_DEVR) load_byte({taddr, 1'b1}, G_DEVR);
						else load_byte({taddr, 1'b0}, G_DEVW);
					P_WLO: ph = P_WHI;
					P_WHI: begin
						sbyte = sbyte << 1; bcnt = bcnt - 4'd1;
						ph = bcnt != 0 ? P_WLO : P_ALO;
					end
					P_ALO: ph = P_AHI;
					P_AHI: begin
						if (it.sda_in) nack = 1;
						ph = P_ATAIL;
					end
					P_ATAIL: begin
						if (nack) ph = P_P1;
						else if (stg == G_DEVW) begin
							if (wide) load_byte(raddr[15:8], G_REGHI);
							else load_byte(raddr[7:0], G_REGLO);
						end else if (stg == G_REGHI) load_byte(raddr[7:0], G_REGLO);
						else if (stg == G_REGLO) begin
							if (rd) begin stg = G_DEVR; ph = P_S1; end
							else begin stg = G_DATA; ph = P_WAIT; end
						end else if (stg == G_DATA) ph = remaining == 0 ? P_P1 : P_WAIT;
						else begin stg = G_READ; sbyte = 0; bcnt = 4'd8; ph = P_RLO; end
					end
					P_RLO: ph = P_RHI;
					P_RHI: begin
						sbyte = {sbyte[6:0], it.sda_in}; bcnt = bcnt - 4'd1;
						if (bcnt != 0) ph = P_RLO;
						else begin
							o.read_data = sbyte; o.read_valid = 1;
							o.read_last = remaining <= 1;
							remaining = o.read_last ? 13'd0 : remaining - 13'd1;
							ph = P_KLO;
						end
					end
					P_KLO: ph = P_KHI;
					P_KHI: if (remaining == 0) ph = P_P1;
						else begin sbyte = 0; bcnt = 4'd8; ph = P_RLO; end
					P_P1: ph = P_P2;
					P_P2: ph = P_P3;
					P_P3: begin
						o.done_res = 1; o.status = nack ? ST_NOACK : ST_OK; ph = P_IDLE;
					end
					default: ph = P_IDLE;
				endcase
			end
		end
		return o;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH item %0d %s: got %0d expected %0d", checked, what, got, want);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
		out_took <= arst_n && out_valid && !out_stall;
	end

	// driver
	always @(negedge clk) begin
		if (!arst_n) begin
			reset_model();
			in_valid <= 0;
			in_data <= '0;
			out_stall <= 0;
		end else begin
			if (in_took) begin
				bus_expected.push_back(bus_tick(in_data));
				sent++;
				in_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
			end
			// a stalled payload is held as it is
			if (!in_valid || in_took) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 0;
				end else if (feeding && tick_queue.size() > 0) begin
					in_data <= tick_queue.pop_front();
					in_valid <= 1;
				end else
					in_valid <= 0;
			end
			if (out_took)
				out_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 12) : 0;
			if (out_gap > 0) begin
				out_gap--;
				out_stall <= 1;
			end else
				out_stall <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (bus_expected.size() == 0) begin
				report_mismatch("unexpected output transfer", 1, 0);
			end else begin
				out_item_t e;
				e = bus_expected.pop_front();
				if (out_data.scl_out !== e.scl_out)
					report_mismatch("scl", out_data.scl_out, e.scl_out);
				if (out_data.sda_out !== e.sda_out)
					report_mismatch("sda", out_data.sda_out, e.sda_out);
				if (out_data.sda_released !== e.sda_released)
					report_mismatch("sda_released", out_data.sda_released, e.sda_released);
				if (out_data.busy_res !== e.busy_res)
					report_mismatch("busy", out_data.busy_res, e.busy_res);
				if (out_data.want_data !== e.want_data)
					report_mismatch("want_data", out_data.want_data, e.want_data);
				if (out_data.read_data !== e.read_data)
					report_mismatch("read_data", out_data.read_data, e.read_data);
				if (out_data.read_valid !== e.read_valid)
					report_mismatch("read_valid", out_data.read_valid, e.read_valid);
				if (out_data.read_last !== e.read_last)
					report_mismatch("read_last", out_data.read_last, e.read_last);
				if (out_data.done_res !== e.done_res)
					report_mismatch("done", out_data.done_res, e.done_res);
				if (out_data.status !== e.status)
					report_mismatch("status", out_data.status, e.status);
				if (e.done_res) ndone++;
				if (e.read_valid) nread++;
				if (e.done_res && e.status == ST_NOACK) nnack++;
				checked++;
			end
		end
	end

	function automatic in_item_t idle_tick(input bit sda);
		in_item_t t;
		t = '0;
		t.command = CMD_NONE;
		t.sda_in = sda;
		t.device_address = 7'($urandom); t.register_address = 16'($urandom);
		t.write_data = 8'($urandom); t.transfer_length = 13'($urandom);
		t.address_bytes = 2'($urandom);
		return t;
	endfunction

	// one complete transfer, ticks computed from the half period; sda is random where ignored
	task automatic queue_transfer(input bit is_read, input bit two, input int len,
			input bit ack_fail, input logic [6:0] dev, input logic [15:0] rg);
		in_item_t t;
		int h, tpb, hdr_ticks;
		h = (half_ticks == 0) ? 1 : int'(half_ticks);
		tpb = 18 * h;
		hdr_ticks = ((two ? 3 : 2) + (is_read ? 1 : 0)) * tpb + (is_read ? 2 * h : 0) + 2 * h;
		t = idle_tick(1'($urandom));
		t.command = is_read ? CMD_READ : CMD_WRITE;
		t.device_address = dev; t.register_address = rg;
		t.address_bytes = two ? 2'd2 : 2'd1; t.transfer_length = 13'(len);
		tick_queue.push_back(t);
		// ack bits are sampled from these; mostly low unless a failure is wanted
		repeat (hdr_ticks)
			tick_queue.push_back(idle_tick(ack_fail ? 1'($urandom) : ($urandom_range(0, 7) == 0)));
		if (!is_read) begin
			for (int i = 0; i < len; i++) begin
				t = idle_tick(1'b0);
				t.command = CMD_DATA;
				t.write_data = 8'($urandom);
				// repeated data commands; ignored unless the block waits
				repeat (3) tick_queue.push_back(t);
				repeat (tpb + 4) tick_queue.push_back(idle_tick($urandom_range(0, 7) == 0));
			end
		end else begin
			repeat (len * tpb) tick_queue.push_back(idle_tick(1'($urandom)));
		end
		repeat (3 * h + 8) tick_queue.push_back(idle_tick(1'($urandom)));
	endtask

	task automatic drain();
		feeding = 1;
		while (tick_queue.size() != 0) @(posedge clk);
		@(posedge clk);
		while (in_valid || bus_expected.size() != 0) @(posedge clk);
		feeding = 0;
		repeat (10) @(posedge clk);
	endtask

	// runs ticks until the bus is idle, handing over data bytes when asked
	task automatic finish_transfer();
		in_item_t t;
		while (ph != P_IDLE) begin
			if (ph == P_WAIT) begin
				t = idle_tick(1'b0);
				t.command = CMD_DATA;
				t.write_data = 8'($urandom);
				tick_queue.push_back(t);
			end
			repeat (64) tick_queue.push_back(idle_tick($urandom_range(0, 3) == 0));
			drain();
		end
	endtask

	task automatic set_half(input logic [15:0] v);
		@(negedge clk);
		cfg_we <= 1; cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		half_ticks = v;
	endtask

	initial begin
		in_item_t t;
		int k;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; feeding = 0;
		half_ticks = HalfPeriodReset;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// rejected starts, and a data command while idle
		t = idle_tick(1'b1); t.command = CMD_WRITE; t.address_bytes = 2'd0;
		t.transfer_length = 13'd1;
		tick_queue.push_back(t);
		t.command = CMD_READ; t.address_bytes = 2'd3; tick_queue.push_back(t);
		t.address_bytes = 2'd1; t.transfer_length = 13'd0; tick_queue.push_back(t);
		t.transfer_length = 13'd4097; tick_queue.push_back(t);
		t.transfer_length = 13'd8191; t.command = CMD_WRITE; tick_queue.push_back(t);
		t.command = CMD_DATA; tick_queue.push_back(t);
		// reset half period for the first phases, then a short one to finish
		t = idle_tick(1'b1); t.command = CMD_READ; t.device_address = 7'h7f;
		t.register_address = 16'hffff; t.address_bytes = 2'd2; t.transfer_length = 13'd1;
		tick_queue.push_back(t);
		repeat (300) tick_queue.push_back(idle_tick(1'b0));
		drain();
		set_half(16'd1);
		finish_transfer();
		set_half(16'd0);
		queue_transfer(1'b0, 1'b1, 2, 1'b0, 7'h00, 16'h0000);
		drain();
		finish_transfer();
		queue_transfer(1'b1, 1'b0, 3, 1'b0, 7'h55, 16'h00ff);
		drain();
		finish_transfer();
		queue_transfer(1'b0, 1'b0, 1, 1'b1, 7'h2a, 16'ha5a5);
		drain();
		finish_transfer();
		set_half(16'd1);
		queue_transfer(1'b1, 1'b1, 2, 1'b1, 7'h7f, 16'h8001);
		drain();
		finish_transfer();
		// longest half period and length; then a short half period and a forced no-ack
		set_half(16'hffff);
		t = idle_tick(1'b0); t.command = CMD_READ; t.address_bytes = 2'd1;
		t.transfer_length = 13'd4096;
		tick_queue.push_back(t);
		repeat (4) tick_queue.push_back(idle_tick(1'b1));
		drain();
		set_half(16'd1);
		repeat (40) tick_queue.push_back(idle_tick(1'b1));
		drain();
		finish_transfer();
		for (int phs = 0; phs < 6; phs++) begin
			set_half(phs == 5 ? 16'd0 : 16'($urandom_range(1, 2)));
			while (sent < 800 + 1050 * (phs + 1) / 6) begin
				k = $urandom_range(0, 9);
				if (k == 0) begin
					t = idle_tick(1'($urandom)); t.command = 2'($urandom_range(1, 3));
					t.transfer_length = 13'($urandom_range(0, 6));
					tick_queue.push_back(t);
				end else if (k == 1)
					queue_transfer(1'($urandom), 1'($urandom), $urandom_range(0, 4), 1'b1,
						7'($urandom), 16'($urandom));
				else
					queue_transfer(1'($urandom), 1'($urandom), $urandom_range(1, 4), 1'b0,
						7'($urandom), 16'($urandom));
				drain();
				finish_transfer();
			end
		end
		repeat (20) @(posedge clk);
		$display("Covered %0d ticks, %0d transfers ended, %0d read bytes, %0d no-ack aborts",
			checked, ndone, nread, nnack);
		if (errors == 0 && bus_expected.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#400ms;
		$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/i2cram_pkg.sv
rtl/i2cram_front.sv
rtl/i2cram_queue.sv
rtl/i2cram_back.sv
rtl/i2c_register_access_master.sv
rtl/i2cram_checker.sv
bench/i2c_register_access_master_tb.sv
